// ===== hdl/key_debounce_longpress_multiclick_macros.svh =====
// Assertion macros shared by the key scanner modules.
`ifndef KEY_DEBOUNCE_LONGPRESS_MULTICLICK_MACROS_SVH
`define KEY_DEBOUNCE_LONGPRESS_MULTICLICK_MACROS_SVH

// Checked on every rising edge of clk, masked while reset is asserted
`define KDLM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included
`define KDLM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kdlm_pkg.sv =====
package kdlm_pkg;

    // Key codes
    localparam logic [7:0] KEY_NONE    = 8'hFF;
    localparam logic [7:0] KEY_POWER   = 8'hFE;
    localparam logic [7:0] KEY_DOWN    = 8'hFD;
    localparam logic [7:0] KEY_UP      = 8'hFB;
    localparam logic [7:0] KEY_SETUP   = 8'hFC;
    localparam logic [7:0] KEY_CONFIRM = 8'hFA;
    localparam logic [7:0] KEY_CLICK1  = 8'hF2;
    localparam logic [7:0] KEY_CLICK2  = 8'hF5;
    localparam logic [7:0] KEY_CLICK3  = 8'hF3;

    // Register indexes
    localparam logic [1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] CFG_LONG_HOLD    = 2'd1;
    localparam logic [1:0] CFG_CLICK_WINDOW = 2'd2;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RST     = 16'd2;
    localparam logic [15:0] LONG_HOLD_RST    = 16'd200;
    localparam logic [7:0]  CLICK_WINDOW_RST = 8'd200;

    localparam logic [7:0] CLICK_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_hold_ticks;
        logic [7:0]  click_window_ticks;
    } cfg_t;

    typedef struct packed {
        logic power_pin;
        logic down_pin;
        logic up_pin;
        logic confirm_pin;
        logic setup_pin;
        logic menu_open;
    } scan_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       long_held;
        logic       notify;
    } result_t;

endpackage

// ===== hdl/kdlm_core.sv =====
// Key state: debounce/hold timer, click window and click counter.
// State advances once per accepted scan word; result is the combinational
// view of the state after that word.
module kdlm_core
    import kdlm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  scan_t   scan,
    input  cfg_t    cfg,
    output result_t res
);

    `include "key_debounce_longpress_multiclick_macros.svh"

    logic [7:0]  stable_code_reg, stable_code_next;
    logic [15:0] hold_timer_reg, hold_timer_next;
    logic [7:0]  click_timer_reg, click_timer_next;
    logic [7:0]  click_count_reg, click_count_next;

    logic [7:0]  code;
    logic [15:0] hold_inc;
    logic        is_dir_key;
    logic        note;

    // Fold the active-low pins into a key code
    always_comb
    begin
        code = KEY_NONE;
        if (!scan.power_pin)   code = code & KEY_POWER;
        if (!scan.down_pin)    code = code & KEY_DOWN;
        if (!scan.up_pin)      code = code & KEY_UP;
        if (!scan.setup_pin)   code = code & KEY_SETUP;
        if (!scan.confirm_pin) code = code & KEY_CONFIRM;
    end

    assign hold_inc   = hold_timer_reg + 16'd1;
    assign is_dir_key = (code == KEY_POWER) || (code == KEY_UP) || (code == KEY_DOWN);

    // Next state for one scan word
    always_comb
    begin
        stable_code_next = stable_code_reg;
        hold_timer_next  = hold_timer_reg;
        click_timer_next = click_timer_reg;
        click_count_next = click_count_reg;
        note             = 1'b0;

        priority if (stable_code_reg != code)
        begin
            // debounce a changed pattern
            hold_timer_next = hold_inc;
            if (hold_inc > cfg.debounce_ticks)
            begin
                stable_code_next = code;
                note             = 1'b1;
                if (code == KEY_CONFIRM)
                begin
                    if (click_count_reg != CLICK_COUNT_MAX)
                        click_count_next = click_count_reg + 8'd1;
                    click_timer_next = cfg.click_window_ticks;
                end
            end
        end
        else if ((is_dir_key && !scan.menu_open) || code == KEY_SETUP)
        begin
            // long-press timing
            if (hold_timer_reg < cfg.long_hold_ticks)
            begin
                hold_timer_next = hold_inc;
                note            = (hold_inc == cfg.long_hold_ticks);
            end
        end
        else if (is_dir_key)
        begin
            // direction key held inside a menu: timer frozen
        end
        else
        begin
            // idle, confirm or a key combination held: run down the click window
            hold_timer_next = '0;
            if (click_timer_reg != 8'd0)
            begin
                click_timer_next = click_timer_reg - 8'd1;
                if (click_timer_reg == 8'd1)
                begin
                    priority if (click_count_reg == 8'd1)
                    begin
                        stable_code_next = KEY_CLICK1;
                        note             = 1'b1;
                    end
                    else if (click_count_reg == 8'd2 && !scan.menu_open)
                    begin
                        stable_code_next = KEY_CLICK2;
                        note             = 1'b1;
                    end
                    else if (click_count_reg == 8'd3 && !scan.menu_open)
                    begin
                        stable_code_next = KEY_CLICK3;
                        note             = 1'b1;
                    end
                    else
                    begin
                    end
                    click_count_next = '0;
                end
            end
        end
    end

    assign res.key_code  = stable_code_next;
    assign res.long_held = (hold_timer_next >= cfg.long_hold_ticks);
    assign res.notify    = note;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_code_reg <= KEY_NONE;
            hold_timer_reg  <= '0;
            click_timer_reg <= '0;
            click_count_reg <= '0;
        end
        else if (accept)
        begin
            stable_code_reg <= stable_code_next;
            hold_timer_reg  <= hold_timer_next;
            click_timer_reg <= click_timer_next;
            click_count_reg <= click_count_next;
        end
    end

    // A changed accepted code must always be flagged
    `KDLM_ASSERT(a_code_change_notifies, (accept && res.key_code != stable_code_reg) |-> res.notify, "code changed without notify")
    // State only moves on an accepted word
    `KDLM_ASSERT(a_state_holds_when_idle, !accept |=> ($stable(stable_code_reg) && $stable(hold_timer_reg) && $stable(click_timer_reg)), "state moved without a word")

endmodule

// ===== hdl/key_debounce_longpress_multiclick.sv =====
// Channel   Handshake           Word
// -------   -----------------   ------------------------------------------------
// scan in   in_valid/in_stall   power_pin down_pin up_pin confirm_pin setup_pin
//                               menu_open
// result    out_valid/out_stall key_code long_held notify
// config    cfg_we              cfg_index cfg_data (no read-back)
//
// One scan word per clock while in_stall is low; its result is registered in the result buffer.
// The key state update is a single compare/increment pass between input and
// result register. A two-entry result buffer keeps input flowing while the
// output is stalled; in_stall rises only when both entries are full.
// Reset (rst_n, async) restores the key state, registers and empties the buffer.
module key_debounce_longpress_multiclick
    import kdlm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        power_pin,
    input  logic        down_pin,
    input  logic        up_pin,
    input  logic        confirm_pin,
    input  logic        setup_pin,
    input  logic        menu_open,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  key_code,
    output logic        long_held,
    output logic        notify,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    `include "key_debounce_longpress_multiclick_macros.svh"

    cfg_t    cfg_reg;
    scan_t   scan;
    result_t res;
    result_t buf_reg [2];
    logic    wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic    in_take, out_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= DEBOUNCE_RST;
            cfg_reg.long_hold_ticks    <= LONG_HOLD_RST;
            cfg_reg.click_window_ticks <= CLICK_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:     cfg_reg.debounce_ticks     <= cfg_data;
                CFG_LONG_HOLD:    cfg_reg.long_hold_ticks    <= cfg_data;
                CFG_CLICK_WINDOW: cfg_reg.click_window_ticks <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign scan = '{power_pin:   power_pin,
                    down_pin:    down_pin,
                    up_pin:      up_pin,
                    confirm_pin: confirm_pin,
                    setup_pin:   setup_pin,
                    menu_open:   menu_open};

    assign in_stall = (count_reg == 2'd2);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    kdlm_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_take),
        .scan   (scan),
        .cfg    (cfg_reg),
        .res    (res)
    );

    // Result buffer: two words
    always_comb
    begin
        count_next = count_reg;
        if (in_take && !out_take)
            count_next = count_reg + 2'd1;
        else if (!in_take && out_take)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_take)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (out_take)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            buf_reg[wr_ptr_reg] <= res;
    end

    assign out_valid = (count_reg != 2'd0);
    assign key_code  = buf_reg[rd_ptr_reg].key_code;
    assign long_held = buf_reg[rd_ptr_reg].long_held;
    assign notify    = buf_reg[rd_ptr_reg].notify;

    // Buffer occupancy never exceeds two words; count is unknown until reset acts
    `KDLM_ASSERT_ALWAYS(a_count_in_range, !rst_n || count_reg != 2'd3, "result buffer overflow")
    // Pointers differ exactly when one word is held
    `KDLM_ASSERT(a_ptr_count_match, (wr_ptr_reg != rd_ptr_reg) == (count_reg == 2'd1), "buffer pointers out of step")

endmodule

// ===== verif/kdlm_scan_checker.sv =====
`timescale 1ns / 100ps

// Watches the scan and result channels of the key scanner, keeps its own copy
// of the key state and registers, and compares every result word in order.
module kdlm_scan_checker
    import kdlm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        power_pin,
    input  logic        down_pin,
    input  logic        up_pin,
    input  logic        confirm_pin,
    input  logic        setup_pin,
    input  logic        menu_open,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  key_code,
    input  logic        long_held,
    input  logic        notify,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          words_checked,
    output int          click_events,
    output int          long_presses
);

    // predictor copy of registers and key state
    cfg_t       regs;
    logic [7:0] stable_code;
    logic [15:0] hold_timer;
    logic [7:0] click_timer;
    logic [7:0] click_count;

    // results still owed by the block, oldest first
    result_t    owed_results[$];

    task automatic report(input string msg);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report($sformatf("word %0d %s got %0h want %0h", words_checked, name, got,
                             want));
        end
    endtask

    // one scan tick: fold pins into a code, run debounce, hold and click logic
    function automatic result_t scan_tick(input scan_t w);
        logic [7:0] code;
        logic       note;
        logic       dir_key;
        result_t    r;
        code = KEY_NONE;
        note = 1'b0;
        if (!w.power_pin)
            code &= KEY_POWER;
        if (!w.down_pin)
            code &= KEY_DOWN;
        if (!w.up_pin)
            code &= KEY_UP;
        if (!w.setup_pin)
            code &= KEY_SETUP;
        if (!w.confirm_pin)
            code &= KEY_CONFIRM;
        dir_key = (code == KEY_POWER) || (code == KEY_UP) || (code == KEY_DOWN);

        if (stable_code != code)
        begin
            // shared timer counts the debounce, never cleared on accept
            hold_timer = hold_timer + 16'd1;
            if (hold_timer > regs.debounce_ticks)
            begin
                stable_code = code;
                note = 1'b1;
                if (code == KEY_CONFIRM)
                begin
                    if (click_count < CLICK_COUNT_MAX)
                        click_count = click_count + 8'd1;
                    click_timer = regs.click_window_ticks;
                end
            end
        end
        else if ((dir_key && !w.menu_open) || code == KEY_SETUP)
        begin
            // long-press timer
            if (hold_timer < regs.long_hold_ticks)
            begin
                hold_timer = hold_timer + 16'd1;
                if (hold_timer == regs.long_hold_ticks)
                begin
                    note = 1'b1;
                    long_presses++;
                end
            end
        end
        else if (!dir_key)
        begin
            // idle, confirm or a key combination held: run down the click window
            hold_timer = 16'd0;
            if (click_timer != 8'd0)
            begin
                click_timer = click_timer - 8'd1;
                if (click_timer == 8'd0)
                begin
                    if (click_count == 8'd1)
                    begin
                        stable_code = KEY_CLICK1;
                        note = 1'b1;
                    end
                    else if (click_count == 8'd2 && !w.menu_open)
                    begin
                        stable_code = KEY_CLICK2;
                        note = 1'b1;
                    end
                    else if (click_count == 8'd3 && !w.menu_open)
                    begin
                        stable_code = KEY_CLICK3;
                        note = 1'b1;
                    end
                    if (note)
                        click_events++;
                    click_count = 8'd0;
                end
            end
        end
        // direction key held with a menu open: timer holds

        r.key_code  = stable_code;
        r.long_held = (hold_timer >= regs.long_hold_ticks);
        r.notify    = note;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        scan_t   word;
        if (!rst_n)
        begin
            regs.debounce_ticks     = DEBOUNCE_RST;
            regs.long_hold_ticks    = LONG_HOLD_RST;
            regs.click_window_ticks = CLICK_WINDOW_RST;
            stable_code   = KEY_NONE;
            hold_timer    = 16'd0;
            click_timer   = 8'd0;
            click_count   = 8'd0;
            owed_results.delete();
            fail_count    = 0;
            pending       = 0;
            words_checked = 0;
            click_events  = 0;
            long_presses  = 0;
        end
        else
        begin
            // result side
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    report($sformatf("result word %0h/%0b/%0b with nothing owed", key_code,
                                     long_held, notify));
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("key_code", key_code, want.key_code);
                    check_field("long_held", {7'd0, long_held}, {7'd0, want.long_held});
                    check_field("notify", {7'd0, notify}, {7'd0, want.notify});
                    words_checked++;
                end
            end

            // scan side
            if (in_valid && !in_stall)
            begin
                word = {power_pin, down_pin, up_pin, confirm_pin, setup_pin, menu_open};
                owed_results.push_back(scan_tick(word));
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE:     regs.debounce_ticks     = cfg_data;
                    CFG_LONG_HOLD:    regs.long_hold_ticks    = cfg_data;
                    CFG_CLICK_WINDOW: regs.click_window_ticks = cfg_data[7:0];
                    default:          ;
                endcase
            end

            pending = owed_results.size();
        end
    end

endmodule

// ===== verif/tb_key_debounce_longpress_multiclick.sv =====
`timescale 1ns / 100ps

module tb_key_debounce_longpress_multiclick;
    import kdlm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_WORDS = 800;
    localparam int RANDOM_PHASES = 8;

    // pressed-key masks, same order as the pins in a scan word
    localparam logic [4:0] PRESS_NONE    = 5'b00000;
    localparam logic [4:0] PRESS_POWER   = 5'b10000;
    localparam logic [4:0] PRESS_DOWN    = 5'b01000;
    localparam logic [4:0] PRESS_UP      = 5'b00100;
    localparam logic [4:0] PRESS_CONFIRM = 5'b00010;
    localparam logic [4:0] PRESS_SETUP   = 5'b00001;
    localparam logic [4:0] PRESS_ALL     = 5'b11111;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        power_pin   = 1'b1;
    logic        down_pin    = 1'b1;
    logic        up_pin      = 1'b1;
    logic        confirm_pin = 1'b1;
    logic        setup_pin   = 1'b1;
    logic        menu_open   = 1'b0;
    logic        out_stall   = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = CFG_DEBOUNCE;
    logic [15:0] cfg_data    = 16'd0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  key_code;
    logic        long_held;
    logic        notify;

    int fail_count;
    int pending;
    int words_checked;
    int click_events;
    int long_presses;

    int cycles     = 0;
    int n_sent     = 0;
    int n_settings = 0;
    bit no_idle    = 1'b0;

    // register values in force, used to size the key sequences
    logic [15:0] cur_debounce;
    logic [15:0] cur_long;
    logic [7:0]  cur_window;

    always #10 clk = ~clk;

    key_debounce_longpress_multiclick u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .power_pin   (power_pin),
        .down_pin    (down_pin),
        .up_pin      (up_pin),
        .confirm_pin (confirm_pin),
        .setup_pin   (setup_pin),
        .menu_open   (menu_open),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_code    (key_code),
        .long_held   (long_held),
        .notify      (notify),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    kdlm_scan_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .power_pin     (power_pin),
        .down_pin      (down_pin),
        .up_pin        (up_pin),
        .confirm_pin   (confirm_pin),
        .setup_pin     (setup_pin),
        .menu_open     (menu_open),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .key_code      (key_code),
        .long_held     (long_held),
        .notify        (notify),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .click_events  (click_events),
        .long_presses  (long_presses)
    );

    // watchdog and random result back-pressure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timed out with %0d result words outstanding", pending);
            $display("status: fail");
            $finish;
        end
        out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 37);
    end

    function automatic scan_t key_word(input logic [4:0] pressed, input logic menu);
        return scan_t'({~pressed, menu});
    endfunction

    // present one scan word, with a random gap first unless no_idle is set, and wait for it to go in
    task automatic send_word(input scan_t w);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        {power_pin, down_pin, up_pin, confirm_pin, setup_pin, menu_open} <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic hold_keys(input logic [4:0] pressed, input logic menu, input int n);
        repeat (n)
            send_word(key_word(pressed, menu));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // all three registers, written back to back once the block is idle
    task automatic set_regs(input logic [15:0] db, input logic [15:0] lh,
                            input logic [7:0] cw);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= db;
        @(posedge clk);
        cfg_index <= CFG_LONG_HOLD;
        cfg_data  <= lh;
        @(posedge clk);
        cfg_index <= CFG_CLICK_WINDOW;
        cfg_data  <= {8'd0, cw};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_debounce = db;
        cur_long     = lh;
        cur_window   = cw;
        n_settings++;
    endtask

    // confirm presses close enough to chain, then wait out the window
    task automatic click_burst();
        int   clicks;
        int   settle;
        logic menu;
        clicks = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        menu   = 1'($urandom_range(1));
        settle = cur_debounce + 1;
        repeat (clicks)
        begin
            hold_keys(PRESS_CONFIRM, menu, settle + $urandom_range(2));
            hold_keys(PRESS_NONE, menu, settle + $urandom_range(2));
        end
        hold_keys(PRESS_NONE, 1'($urandom_range(1)), cur_window + $urandom_range(3));
    endtask

    // hold one direction or setup key around the long-press count
    task automatic long_press();
        logic [4:0] k;
        logic       menu;
        int         n;
        case ($urandom_range(3))
            0:       k = PRESS_POWER;
            1:       k = PRESS_UP;
            2:       k = PRESS_DOWN;
            default: k = PRESS_SETUP;
        endcase
        menu = ($urandom_range(3) == 0);
        if ($urandom_range(3) == 0)
            n = $urandom_range(1, cur_long);
        else
            n = cur_debounce + 1 + cur_long + $urandom_range(4);
        hold_keys(k, menu, n);
        hold_keys(PRESS_NONE, menu, cur_debounce + 1 + $urandom_range(2));
    endtask

    task automatic noise(input int n);
        repeat (n)
            send_word(scan_t'(6'($urandom_range(63))));
    endtask

    initial
    begin
        int ph;
        int pick;
        int stop_at;
        bit paused;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        cur_debounce = DEBOUNCE_RST;
        cur_long     = LONG_HOLD_RST;
        cur_window   = CLICK_WINDOW_RST;
        n_settings   = 1;

        // reset register values: debounce of two ticks
        hold_keys(PRESS_POWER, 1'b0, 4);
        hold_keys(PRESS_NONE, 1'b0, 4);

        // short directed checks at tight timing
        set_regs(16'd0, 16'd2, 8'd2);
        hold_keys(PRESS_ALL, 1'b1, 1);
        hold_keys(PRESS_NONE, 1'b1, 1);
        hold_keys(PRESS_POWER, 1'b0, 3);
        hold_keys(PRESS_UP, 1'b1, 3);
        hold_keys(PRESS_SETUP, 1'b1, 3);
        hold_keys(PRESS_CONFIRM, 1'b0, 1);
        hold_keys(PRESS_NONE, 1'b0, 3);

        // random sequences, one register setting per phase
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                set_regs(16'd0, 16'd1, 8'd1);
            else
                set_regs(16'($urandom_range(4)), 16'($urandom_range(1, 24)),
                         8'($urandom_range(1, 20)));
            no_idle = (ph == 3);
            stop_at = n_sent + RANDOM_WORDS / RANDOM_PHASES;
            paused  = 1'b0;
            while (n_sent < stop_at)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    click_burst();
                else if (pick < 55)
                    long_press();
                else if (pick < 80)
                    hold_keys(5'($urandom_range(31)), 1'($urandom_range(1)),
                              $urandom_range(1, cur_debounce + 3));
                else
                    noise($urandom_range(1, 8));
                // one mid-phase stop until the block has caught up
                if (ph == 5 && !paused && n_sent >= stop_at - RANDOM_WORDS / 16)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        no_idle = 1'b0;

        // click count saturation with the widest window and longest hold
        set_regs(16'd0, 16'hFFFF, 8'hFF);
        repeat (260)
        begin
            hold_keys(PRESS_CONFIRM, 1'b0, 1 + $urandom_range(1));
            hold_keys(PRESS_NONE, 1'b0, 1 + $urandom_range(1));
        end
        hold_keys(PRESS_NONE, 1'b0, 260);
        hold_keys(PRESS_POWER, 1'b0, 40);

        // debounce one below its top value: nothing gets accepted
        set_regs(16'd65534, 16'hFFFF, 8'hFF);
        noise(100);

        // no long press and no click window
        set_regs(16'd1, 16'd0, 8'd0);
        stop_at = n_sent + 100;
        while (n_sent < stop_at)
        begin
            if ($urandom_range(1))
                click_burst();
            else
                long_press();
        end

        // debounce at its top value, never accepts
        set_regs(16'hFFFF, 16'd3, 8'd5);
        noise(100);

        drain();
        repeat (4)
            @(posedge clk);

        $display("checked %0d scan words across %0d register settings", words_checked,
                 n_settings);
        $display("saw %0d click events and %0d long presses, %0d mismatches", click_events,
                 long_presses, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/kdlm_pkg.sv
hdl/kdlm_core.sv
hdl/key_debounce_longpress_multiclick.sv
verif/kdlm_scan_checker.sv
verif/tb_key_debounce_longpress_multiclick.sv
